FILE: hw/rtl/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

  // Field and register widths
  localparam int DATA_W    = 16;  // measurement, signed integer
  localparam int EST_W     = 32;  // estimate, signed Q16.16
  localparam int REG_W     = 24;  // noise and covariance registers, unsigned Q8.16
  localparam int CFG_IDX_W = 2;

  // Default gain precision, fraction bits of K
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_Q  = 2'd0;  // process noise
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_R  = 2'd1;  // measurement noise
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_P0 = 2'd2;  // initial error covariance

  // Register reset values
  localparam logic [REG_W-1:0] RST_Q  = 24'd655;
  localparam logic [REG_W-1:0] RST_R  = 24'd65536;
  localparam logic [REG_W-1:0] RST_P0 = 24'd65536;

  // Controller to datapath commands, at most one active per cycle
  typedef struct packed {
    logic load;      // capture accepted measurement
    logic pred;      // prediction, divider setup, innovation
    logic div_step;  // one quotient bit of the gain
    logic mul_x;     // innovation times gain
    logic upd_x;     // round, add, saturate estimate
    logic mul_p;     // covariance times (1 - K)
    logic upd_p;     // store new covariance
    logic push;      // load output register
  } skf_cmd_t;

endpackage

FILE: hw/rtl/skf_ctrl.sv
// Sequencer for the scalar Kalman filter: accept, predict, divide, update, deliver.
module skf_ctrl #(
  parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output skf_pkg::skf_cmd_t cmd
);
  import skf_pkg::*;

  localparam int CNT_W = $clog2(GAIN_FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_FRAC_BITS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PRED = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_MULX = 8'b0000_1000,
    S_UPDX = 8'b0001_0000,
    S_MULP = 8'b0010_0000,
    S_UPDP = 8'b0100_0000,
    S_PUSH = 8'b1000_0000
  } skf_state_t;

  skf_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PRED;
        end
      end
      S_PRED: begin
        cmd.pred  = 1'b1;
        cnt_nxt   = CNT_LAST;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_MULX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_UPDX;
      end
      S_UPDX: begin
        cmd.upd_x = 1'b1;
        state_nxt = S_MULP;
      end
      S_MULP: begin
        cmd.mul_p = 1'b1;
        state_nxt = S_UPDP;
      end
      S_UPDP: begin
        cmd.upd_p = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        // wait until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/skf_dp.sv
// Datapath of the scalar Kalman filter: registers, gain divider, shared multiplier.
module skf_dp #(
  parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  skf_pkg::skf_cmd_t                    cmd,
  input  logic        [skf_pkg::DATA_W-1:0]    in_data,
  input  logic                                 cfg_we,
  input  logic        [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [skf_pkg::REG_W-1:0]     cfg_data,
  output logic        [skf_pkg::EST_W-1:0]     out_data
);
  import skf_pkg::*;

  localparam int G    = GAIN_FRAC_BITS;
  localparam int KW   = G + 1;              // K in 0 .. 2^G
  localparam int DENW = REG_W + 1;          // P1 + R
  localparam int REMW = REG_W + 2;          // partial remainder, below 2 * den
  localparam int INW  = EST_W + 1;          // innovation
  localparam int PW   = INW + KW + 1;       // product width
  localparam logic [KW-1:0] K_ONE = KW'(1) << G;
  localparam logic [PW-1:0] HALF  = PW'(1) << (G - 1);

  // Configuration and filter state
  logic        [REG_W-1:0] q_r, q_nxt;
  logic        [REG_W-1:0] r_r, r_nxt;
  logic        [REG_W-1:0] p0_r, p0_nxt;
  logic                    cfg_hit;
  logic signed [EST_W-1:0] x_r, x_nxt;
  logic        [REG_W-1:0] p_r, p_nxt;

  // Per-item working registers
  logic signed [DATA_W-1:0] m_r;
  logic        [REG_W-1:0]  p1_r;
  logic        [DENW-1:0]   den_r;
  logic        [REMW-1:0]   rem_r;
  logic        [KW-1:0]     quo_r;
  logic signed [INW-1:0]    innov_r;
  logic signed [PW-1:0]     prod_r;
  logic        [EST_W-1:0]  out_r;

  // Combinational
  logic [REG_W:0]          p_sum;
  logic [REG_W-1:0]        p1;
  logic [DENW-1:0]         den;
  logic signed [INW-1:0]   innov;
  logic                    div_bit;
  logic [REMW-1:0]         rem_sub;
  logic [KW-1:0]           k_val;
  logic [KW-1:0]           k_rest;
  logic signed [INW-1:0]   mul_a;
  logic signed [KW:0]      mul_b;
  logic signed [PW-1:0]    rnd;
  logic signed [PW-1:0]    d_val;
  logic signed [PW-1:0]    nx;

  // Register write decode; any valid write reloads the filter state
  always_comb begin
    q_nxt   = q_r;
    r_nxt   = r_r;
    p0_nxt  = p0_r;
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_Q: begin
          q_nxt   = cfg_data;
          cfg_hit = 1'b1;
        end
        CFG_IDX_R: begin
          r_nxt   = cfg_data;
          cfg_hit = 1'b1;
        end
        CFG_IDX_P0: begin
          p0_nxt  = cfg_data;
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Prediction: saturating P + Q, then the gain denominator and the innovation
  assign p_sum = {1'b0, p_r} + {1'b0, q_r};
  assign p1    = p_sum[REG_W] ? {REG_W{1'b1}} : p_sum[REG_W-1:0];
  assign den   = {1'b0, p1} + {1'b0, r_r};
  assign innov = $signed({m_r[DATA_W-1], m_r, 16'b0}) - $signed({x_r[EST_W-1], x_r});

  // Restoring divider, one quotient bit per step
  assign div_bit = (rem_r >= {1'b0, den_r});
  assign rem_sub = div_bit ? (rem_r - {1'b0, den_r}) : rem_r;

  // Zero denominator forces a zero gain
  assign k_val  = (den_r == '0) ? '0 : quo_r;
  assign k_rest = K_ONE - k_val;

  // Shared multiplier operands
  assign mul_a = cmd.mul_x ? innov_r : $signed({{(INW-REG_W){1'b0}}, p1_r});
  assign mul_b = cmd.mul_x ? $signed({1'b0, k_val}) : $signed({1'b0, k_rest});

  // Estimate update: round to nearest, ties up, then saturate
  assign rnd   = prod_r + $signed(HALF);
  assign d_val = rnd >>> G;
  assign nx    = d_val + $signed({{(PW-EST_W){x_r[EST_W-1]}}, x_r});

  always_comb begin
    if ((&nx[PW-1:EST_W-1]) || !(|nx[PW-1:EST_W-1])) begin
      x_nxt = nx[EST_W-1:0];
    end else if (nx[PW-1]) begin
      x_nxt = {1'b1, {(EST_W-1){1'b0}}};
    end else begin
      x_nxt = {1'b0, {(EST_W-1){1'b1}}};
    end
  end

  // Covariance update: floor(P1 * (1 - K))
  assign p_nxt = prod_r[G+REG_W-1:G];

  // Configuration and filter state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= RST_Q;
      r_r  <= RST_R;
      p0_r <= RST_P0;
      x_r  <= '0;
      p_r  <= RST_P0;
    end else begin
      q_r  <= q_nxt;
      r_r  <= r_nxt;
      p0_r <= p0_nxt;
      if (cfg_hit) begin
        x_r <= '0;
        p_r <= p0_nxt;
      end else begin
        if (cmd.upd_x) begin
          x_r <= x_nxt;
        end
        if (cmd.upd_p) begin
          p_r <= p_nxt;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r <= in_data;
    end
    if (cmd.pred) begin
      p1_r    <= p1;
      den_r   <= den;
      rem_r   <= {2'b00, p1};
      quo_r   <= '0;
      innov_r <= innov;
    end
    if (cmd.div_step) begin
      rem_r <= {rem_sub[REMW-2:0], 1'b0};
      quo_r <= {quo_r[KW-2:0], div_bit};
    end
    if (cmd.mul_x || cmd.mul_p) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.push) begin
      out_r <= x_r;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hw/rtl/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: sequencer, datapath and checks.
// One-dimensional Kalman filter. Each transfer on the input carries one signed 16-bit
// sample; the block returns one signed Q16.16 estimate per sample, in order. The time
// from transfer to result is set by the restoring divider that forms the gain one
// quotient bit per cycle and by the single multiplier shared between the estimate and
// covariance updates. The input is ready again as soon as the result sits in the
// output register, even while that result waits to be taken. Register writes (index 0
// process noise, 1 measurement noise, 2 initial error, all unsigned Q8.16) take effect
// at once and restart the filter with a zero estimate and the initial error; writes to
// index 3 are ignored.
module scalar_kalman_filter #(
  parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [skf_pkg::DATA_W-1:0]          in_tdata,   // [15:0] measurement
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [skf_pkg::EST_W-1:0]           out_tdata,  // [31:0] estimate
  input  logic                                cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [skf_pkg::REG_W-1:0]           cfg_data
);
  import skf_pkg::*;

  skf_cmd_t cmd;

  skf_ctrl #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd)
  );

  skf_dp #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_data (out_tdata)
  );

`ifndef SYNTH
  // Commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command active");

  // An accepted sample keeps the input closed while it is processed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after a transfer");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_tvalid || out_tready))
    else $error("output register loaded while a result is pending");

  // A taken result leaves the output empty unless a new one is loaded
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !cmd.push) |=> !out_tvalid)
    else $error("output still valid after its transfer");
`endif

endmodule

FILE: test/scalar_kalman_filter_test.sv
// Self-checking testbench for the scalar Kalman filter: stream driver, monitor and predictor.
module scalar_kalman_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import skf_pkg::*;

  localparam int GAIN_BITS = GAIN_FRAC_BITS_DEF;
  localparam logic [63:0] GAIN_ONE = 64'd1 << GAIN_BITS;
  localparam longint ROUND_HALF = longint'(GAIN_ONE >> 1);
  localparam logic [REG_W-1:0] COV_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;  // unmapped index, write is dropped
  localparam longint EST_MAX = longint'(64'h7FFF_FFFF);
  localparam longint EST_MIN = -longint'(64'h8000_0000);
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 48;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 55;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;  // [15:0] measurement
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [EST_W-1:0] out_tdata;       // [31:0] estimate
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  // Filter registers and state as the block should hold them
  logic [REG_W-1:0] reg_q = RST_Q;
  logic [REG_W-1:0] reg_r = RST_R;
  logic [REG_W-1:0] reg_p0 = RST_P0;
  logic signed [EST_W-1:0] est_q1616 = '0;
  logic [REG_W-1:0] cov_q816 = RST_P0;

  logic [DATA_W-1:0] pending_samples[$];
  logic [EST_W-1:0] expected_estimates[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;

  scalar_kalman_filter DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One filter update: predict, gain, estimate and covariance; returns the new estimate
  function automatic logic [EST_W-1:0] kalman_step(input logic signed [DATA_W-1:0] sample);
    logic [REG_W:0] cov_sum;
    logic [REG_W-1:0] cov_pred;
    logic [REG_W+1:0] denom;
    logic [63:0] gain;
    logic [63:0] cov_next;
    longint innov;
    longint prod;
    longint delta;
    longint next_est;
    cov_sum = {1'b0, cov_q816} + {1'b0, reg_q};
    cov_pred = cov_sum[REG_W] ? COV_MAX : cov_sum[REG_W-1:0];
    denom = {2'b0, cov_pred} + {2'b0, reg_r};
    // zero denominator leaves the gain at zero
    if (denom == '0) gain = '0;
    else gain = (64'(cov_pred) << GAIN_BITS) / 64'(denom);
    if (gain > GAIN_ONE) gain = GAIN_ONE;
    // round to nearest, ties up, then saturate to 32 bits
    innov = longint'(sample) * 65536 - longint'(est_q1616);
    prod = innov * longint'(gain);
    delta = (prod + ROUND_HALF) >>> GAIN_BITS;
    next_est = longint'(est_q1616) + delta;
    if (next_est > EST_MAX) next_est = EST_MAX;
    else if (next_est < EST_MIN) next_est = EST_MIN;
    est_q1616 = next_est[EST_W-1:0];
    cov_next = 64'(cov_pred) * (GAIN_ONE - gain);
    cov_q816 = cov_next[GAIN_BITS +: REG_W];
    return est_q1616;
  endfunction

  // Register write; any mapped index restarts the filter
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    logic mapped;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    mapped = 1'b1;
    case (idx)
      CFG_IDX_Q: reg_q = value;
      CFG_IDX_R: reg_r = value;
      CFG_IDX_P0: reg_p0 = value;
      default: mapped = 1'b0;
    endcase
    if (mapped) begin
      est_q1616 = '0;
      cov_q816 = reg_p0;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(input int value);
    pending_samples.push_back(value[DATA_W-1:0]);
  endtask

  // Wait until every queued sample went in and every estimate came out
  task automatic drain();
    while (pending_samples.size() != 0 || in_tvalid || expected_estimates.size() != 0)
      @(negedge clk);
  endtask

  // Input driver; the estimate is predicted at each input transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) expected_estimates.push_back(kalman_step(in_tdata));
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_samples.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_req) hold_left <= HOLD_CYCLES;
  end

  // Output monitor and receiver back-pressure
  always @(posedge clk) begin : check_estimates
    logic [EST_W-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_estimates.size() == 0) begin
          error_count++;
          $display("%0t: estimate with none expected: actual %0d (0x%08h)",
                   $time, $signed(out_tdata), out_tdata);
        end else begin
          want = expected_estimates.pop_front();
          if (out_tdata !== want) begin
            error_count++;
            $display("%0t: estimate mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
                     $time, $signed(want), want, $signed(out_tdata), out_tdata);
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int level;
    int n_writes;
    int sample;
    logic [REG_W-1:0] reg_value;
    logic [CFG_IDX_W-1:0] reg_index;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: sample extremes and bit patterns
    @(negedge clk);
    send(32767); send(-32768); send(0); send(-1); send(1); send(21845); send(-21846);
    drain();

    // Unmapped index: nothing changes, filter keeps its state
    write_reg(CFG_IDX_NONE, 24'($urandom));
    @(negedge clk);
    send(100); send(-100);
    drain();

    // Covariance overflow with everything at maximum
    write_reg(CFG_IDX_Q, COV_MAX);
    write_reg(CFG_IDX_R, COV_MAX);
    write_reg(CFG_IDX_P0, COV_MAX);
    @(negedge clk);
    send(32767); send(-32768); send(0);
    drain();

    // Zero denominator: estimate must stay put
    write_reg(CFG_IDX_Q, '0);
    write_reg(CFG_IDX_R, '0);
    write_reg(CFG_IDX_P0, '0);
    @(negedge clk);
    send(32767); send(-32768);
    drain();

    // Zero measurement noise: unity gain, estimate follows the sample
    write_reg(CFG_IDX_Q, RST_Q);
    write_reg(CFG_IDX_P0, RST_P0);
    @(negedge clk);
    send(-32768); send(32767); send(1234);
    drain();

    // Tiny gain against huge noise
    write_reg(CFG_IDX_Q, 24'd1);
    write_reg(CFG_IDX_R, COV_MAX);
    write_reg(CFG_IDX_P0, 24'd1);
    @(negedge clk);
    send(32767); send(-32768); send(32767);
    drain();

    // Random phases over all pacing modes
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      n_writes = $urandom_range(1, 3);
      repeat (n_writes) begin
        reg_index = CFG_IDX_W'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
          0: reg_value = '0;
          1: reg_value = COV_MAX;
          2: reg_value = REG_W'($urandom_range(0, 1 << 12));
          3: reg_value = REG_W'($urandom_range(0, 1 << 20));
          default: reg_value = REG_W'($urandom);
        endcase
        write_reg(reg_index, reg_value);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 72; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 72; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      level = $urandom_range(0, 65535) - 32768;
      @(negedge clk);
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0: sample = $urandom_range(0, 1) ? 32767 : -32768;
          1, 2: sample = $urandom_range(0, 65535) - 32768;
          default: begin
            // noisy readings around a steady level
            sample = level + $urandom_range(0, 200) - 100;
            if (sample > 32767) sample = 32767;
            if (sample < -32768) sample = -32768;
          end
        endcase
        send(sample);
      end
      // receiver holds off while the sender keeps offering
      if (ph == 0) begin
        hold_req = 1'b1;
        wait (hold_left != 0);
        hold_req = 1'b0;
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
